@@ design/dsca_pkg.sv @@
// ----------------------------------------------------------------------------
// Disk sector chain addresser: shared package
// Word types, format and status codes, controller states and the zone rule
// used to place a track/sector link within a disk image.
// ----------------------------------------------------------------------------
`default_nettype none

package dsca_pkg;

    // Default number of tracks the mark store covers.
    localparam int DEF_TRACK_CAP = 80;

    // Width of the chain epoch kept in each mark store entry.
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_ONE = {{(EPOCH_W-1){1'b0}}, 1'b1};

    // Status codes of a result word.
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_END  = 2'd1;
    localparam logic [1:0] STAT_LOOP = 2'd2;
    localparam logic [1:0] STAT_BAD  = 2'd3;

    // Command codes of an input word.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    // Image lengths in bytes that identify a known geometry.
    localparam logic [19:0] SIZE_35A = 20'd174848;
    localparam logic [19:0] SIZE_35B = 20'd175531;
    localparam logic [19:0] SIZE_40A = 20'd196608;
    localparam logic [19:0] SIZE_40B = 20'd197376;
    localparam logic [19:0] SIZE_42A = 20'd205312;
    localparam logic [19:0] SIZE_42B = 20'd206114;
    localparam logic [19:0] SIZE_70A = 20'd349696;
    localparam logic [19:0] SIZE_70B = 20'd351062;
    localparam logic [19:0] SIZE_80A = 20'd819200;
    localparam logic [19:0] SIZE_80B = 20'd822400;

    // Sectors on the first side of a double-sided image.
    localparam logic [11:0] SIDE_SECTORS = 12'd683;
    localparam logic [7:0]  SIDE_TRACKS  = 8'd35;
    localparam logic [5:0]  WIDE_COUNT   = 6'd40;

    typedef enum logic [1:0] {
        FMT_NONE,
        FMT_SINGLE,
        FMT_DOUBLE,
        FMT_WIDE
    } fmt_t;

    typedef enum logic [1:0] {
        CTRL_CLEAR,
        CTRL_IDLE,
        CTRL_CHECK
    } ctrl_state_t;

    // Input word: one link of a chain.
    typedef struct packed {
        logic       cmd;
        logic [7:0] track;
        logic [7:0] sector;
    } link_in_t;

    // Result word.
    typedef struct packed {
        logic [19:0] byte_offset;
        logic [1:0]  status;
    } link_out_t;

    // Geometry of the track named by the current input word.
    typedef struct packed {
        logic        known;
        logic [6:0]  limit;
        logic [5:0]  count;
        logic [11:0] preceding;
    } link_geom_t;

    // Sectors per track of the zone rule for a side-relative track.
    function automatic logic [5:0] zone_count(input logic [7:0] t);
        logic [5:0] res;
        if (t <= 8'd17) begin
            res = 6'd21;
        end else if (t <= 8'd24) begin
            res = 6'd19;
        end else if (t <= 8'd30) begin
            res = 6'd18;
        end else begin
            res = 6'd17;
        end
        return res;
    endfunction

    // Sectors before a side-relative track under the zone rule.
    function automatic logic [11:0] zone_before(input logic [7:0] t);
        logic [11:0] tw;
        logic [11:0] res;
        tw = {4'd0, t};
        if (t <= 8'd17) begin
            res = (tw - 12'd1) * 12'd21;
        end else if (t <= 8'd24) begin
            res = 12'd357 + (tw - 12'd18) * 12'd19;
        end else if (t <= 8'd30) begin
            res = 12'd490 + (tw - 12'd25) * 12'd18;
        end else begin
            res = 12'd598 + (tw - 12'd31) * 12'd17;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ design/dsca_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module dsca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ design/dsca_geom.sv @@
// ----------------------------------------------------------------------------
// Disk sector chain addresser: geometry unit
// Decodes each image size written into a format and track limit held in a
// register, and gives the sector count and the sectors before the track
// of the current input word.
// ----------------------------------------------------------------------------
`default_nettype none

module dsca_geom
    import dsca_pkg::*;
#(
    parameter int TRACK_CAP = DEF_TRACK_CAP
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [19:0] cfg_image_size,
    input  wire logic [7:0]  track,
    output      link_geom_t  geom
);

    fmt_t       fmt_reg;
    logic [6:0] limit_reg;
    fmt_t       fmt_dec;
    logic [6:0] tracks_dec;
    logic [6:0] limit_dec;
    logic [7:0] side_track;

    // The register is always ready to take a word.
    assign cfg_ready = 1'b1;

    // Decode an image length into a format and track count.
    always_comb begin
        fmt_dec    = FMT_NONE;
        tracks_dec = 7'd0;
        case (cfg_image_size) inside
            SIZE_35A, SIZE_35B: begin
                fmt_dec    = FMT_SINGLE;
                tracks_dec = 7'd35;
            end
            SIZE_40A, SIZE_40B: begin
                fmt_dec    = FMT_SINGLE;
                tracks_dec = 7'd40;
            end
            SIZE_42A, SIZE_42B: begin
                fmt_dec    = FMT_SINGLE;
                tracks_dec = 7'd42;
            end
            SIZE_70A, SIZE_70B: begin
                fmt_dec    = FMT_DOUBLE;
                tracks_dec = 7'd70;
            end
            SIZE_80A, SIZE_80B: begin
                fmt_dec    = FMT_WIDE;
                tracks_dec = 7'd80;
            end
            default: begin
                fmt_dec    = FMT_NONE;
                tracks_dec = 7'd0;
            end
        endcase
        limit_dec = (tracks_dec < 7'(TRACK_CAP)) ? tracks_dec : 7'(TRACK_CAP);
    end

    // Decoded geometry register, loaded on each configuration write.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fmt_reg   <= FMT_NONE;
            limit_reg <= 7'd0;
        end else if (cfg_valid && cfg_ready) begin
            fmt_reg   <= fmt_dec;
            limit_reg <= limit_dec;
        end
    end

    // Placement of the requested track within the image.
    assign side_track = track - SIDE_TRACKS;

    always_comb begin
        geom.known = (fmt_reg != FMT_NONE);
        geom.limit = limit_reg;
        if (fmt_reg == FMT_WIDE) begin
            geom.count     = WIDE_COUNT;
            geom.preceding = ({4'd0, track} - 12'd1) * 12'd40;
        end else if (fmt_reg == FMT_DOUBLE && track > SIDE_TRACKS) begin
            geom.count     = zone_count(side_track);
            geom.preceding = SIDE_SECTORS + zone_before(side_track);
        end else begin
            geom.count     = zone_count(track);
            geom.preceding = zone_before(track);
        end
    end

endmodule

`default_nettype wire

@@ design/dsca_ctrl.sv @@
// ----------------------------------------------------------------------------
// Disk sector chain addresser: controller
// Reads the mark store entry of each link, checks it against the current
// chain epoch, writes the mark back and loads the result register. Runs the
// clearing sweep after reset and when the epoch wraps.
// ----------------------------------------------------------------------------
`default_nettype none

module dsca_ctrl
    import dsca_pkg::*;
#(
    parameter int TRACK_CAP = DEF_TRACK_CAP,
    parameter int DEPTH     = (TRACK_CAP + 1) * 256,
    parameter int AW        = $clog2(DEPTH)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_stall,
    input  wire link_in_t           in_word,
    input  wire link_geom_t         geom,
    output      logic               out_valid,
    input  wire logic               out_stall,
    output      link_out_t          out_word,
    output      logic               ram_we,
    output      logic [AW-1:0]      ram_waddr,
    output      logic [EPOCH_W-1:0] ram_wdata,
    output      logic               ram_re,
    output      logic [AW-1:0]      ram_raddr,
    input  wire logic [EPOCH_W-1:0] ram_rdata
);

    ctrl_state_t        state_reg;
    ctrl_state_t        state_next;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic               pend_reg;
    logic               fresh_reg;
    logic [7:0]         track_reg;
    logic [7:0]         sector_reg;
    link_geom_t         geom_reg;
    logic [AW-1:0]      addr_reg;
    logic               out_valid_reg;
    link_out_t          out_word_reg;

    logic               accept;
    logic               out_free;
    logic               load_out;
    logic               clr_last;
    logic               wrap;
    logic               visited;
    logic               mark;
    logic [11:0]        sector_sum;
    link_out_t          result;

    // Mark store address of the incoming link: track above sector.
    assign ram_raddr = {in_word.track[AW-9:0], in_word.sector};

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign clr_last = (clr_addr_reg == AW'(DEPTH - 1));
    assign wrap     = (epoch_reg == '1);

    // Check of the held link against the mark read in the accept cycle.
    always_comb begin
        visited    = !fresh_reg && (ram_rdata == epoch_reg);
        mark       = 1'b0;
        sector_sum = geom_reg.preceding + {4'd0, sector_reg};
        result.byte_offset = 20'd0;
        if (!geom_reg.known) begin
            result.status = STAT_BAD;
        end else if (track_reg == 8'd0) begin
            result.status = STAT_END;
        end else if (track_reg > {1'b0, geom_reg.limit}) begin
            result.status = STAT_LOOP;
        end else if (visited) begin
            result.status = STAT_LOOP;
        end else begin
            mark = 1'b1;
            if (sector_reg >= {2'd0, geom_reg.count}) begin
                result.status = STAT_BAD;
            end else begin
                result.status      = STAT_OK;
                result.byte_offset = {sector_sum, 8'd0};
            end
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CTRL_CLEAR: begin
                if (clr_last) begin
                    state_next = pend_reg ? CTRL_CHECK : CTRL_IDLE;
                end
            end
            CTRL_IDLE: begin
                if (accept) begin
                    state_next = (in_word.cmd == CMD_START && wrap) ? CTRL_CLEAR
                                                                   : CTRL_CHECK;
                end
            end
            CTRL_CHECK: begin
                if (out_free) begin
                    state_next = CTRL_IDLE;
                end
            end
            default: begin
                state_next = CTRL_CLEAR;
            end
        endcase
    end

    // State outputs: handshake and mark store control.
    always_comb begin
        in_stall  = 1'b1;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = epoch_reg;
        load_out  = 1'b0;
        case (state_reg)
            CTRL_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            CTRL_IDLE: begin
                in_stall = 1'b0;
                ram_re   = in_valid;
            end
            CTRL_CHECK: begin
                load_out = out_free;
                ram_we   = out_free && mark;
            end
            default: begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= CTRL_CLEAR;
            epoch_reg     <= EPOCH_ONE;
            clr_addr_reg  <= '0;
            pend_reg      <= 1'b0;
            fresh_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            // Sweep and epoch handling.
            if (state_reg == CTRL_CLEAR) begin
                if (clr_last) begin
                    epoch_reg <= EPOCH_ONE;
                    fresh_reg <= pend_reg;
                    pend_reg  <= 1'b0;
                end else begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                end
            end else if (accept && in_word.cmd == CMD_START) begin
                if (wrap) begin
                    pend_reg     <= 1'b1;
                    clr_addr_reg <= '0;
                end else begin
                    epoch_reg <= epoch_reg + EPOCH_ONE;
                end
            end

            if (load_out) begin
                fresh_reg <= 1'b0;
            end

            // Result register valid.
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Held link and result payload.
    always_ff @(posedge clk) begin
        if (accept) begin
            track_reg  <= in_word.track;
            sector_reg <= in_word.sector;
            geom_reg   <= geom;
            addr_reg   <= ram_raddr;
        end
        if (load_out) begin
            out_word_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // A waiting result is never overwritten.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !load_out)
        else $error("result register overwritten while stalled");

    // An accepted link is checked next or waits for a sweep.
    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == CTRL_CHECK || state_reg == CTRL_CLEAR))
        else $error("accepted link not followed by check or sweep");

    // The swept store flag is only live for the link that waited on it.
    a_fresh_check: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg |-> (state_reg == CTRL_CHECK))
        else $error("fresh flag outside of the check state");

    // The epoch moves only on a chain start or at the end of a sweep.
    a_epoch_move: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(epoch_reg) |->
            ($past(accept && in_word.cmd == CMD_START) || $past(state_reg == CTRL_CLEAR)))
        else $error("epoch changed without a chain start or sweep");

endmodule

`default_nettype wire

@@ design/disk_sector_chain_addresser_top.sv @@
// ----------------------------------------------------------------------------
// Disk sector chain addresser: top level
// Turns track/sector links of a sector chain into byte offsets in a disk
// image and flags loops, using an epoch-tagged mark store.
//
//   Channel  Direction  Handshake            Word
//   in       input      in_valid / in_stall  link_in_t  (cmd, track, sector)
//   out      output     out_valid/out_stall  link_out_t (byte_offset, status)
//   cfg      input      cfg_valid/cfg_ready  image size in bytes
//
// The accept cycle reads the mark store entry of a link; the check state then
// checks it against the registered read data, writes the mark back and loads
// the result register.
// After reset a sweep over all (TRACK_CAP + 1) * 256 entries (20736 by default)
// clears the mark store before the first word is taken.
// Every 255th chain start runs the same sweep before its link is checked.
// A stalled output holds the check state; a word may be taken while a
// finished result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module disk_sector_chain_addresser_top
    import dsca_pkg::*;
#(
    parameter int TRACK_CAP = DEF_TRACK_CAP
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire link_in_t    in_word,
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      link_out_t   out_word,
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [19:0] cfg_image_size
);

    localparam int DEPTH = (TRACK_CAP + 1) * 256;
    localparam int AW    = $clog2(DEPTH);

    link_geom_t         geom;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [EPOCH_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [EPOCH_W-1:0] ram_rdata;

    // Image size register and track placement.
    dsca_geom #(
        .TRACK_CAP(TRACK_CAP)
    ) u_geom (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_image_size(cfg_image_size),
        .track         (in_word.track),
        .geom          (geom)
    );

    // Link sequencing and result register.
    dsca_ctrl #(
        .TRACK_CAP(TRACK_CAP),
        .DEPTH    (DEPTH),
        .AW       (AW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .geom     (geom),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_word (out_word),
        .ram_we   (ram_we),
        .ram_waddr(ram_waddr),
        .ram_wdata(ram_wdata),
        .ram_re   (ram_re),
        .ram_raddr(ram_raddr),
        .ram_rdata(ram_rdata)
    );

    // Mark store: one chain epoch per track/sector slot.
    dsca_ram #(
        .WIDTH(EPOCH_W),
        .DEPTH(DEPTH)
    ) u_marks (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

endmodule

`default_nettype wire

@@ sim/disk_sector_chain_addresser_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Disk sector chain addresser: self-checking testbench
// Feeds track/sector link words through the in channel under random gaps and
// output stalls, predicts each result word from a software copy of the
// geometry and visited marks, and compares every result field by field.
// The image size register is rewritten between phases, once the block has
// drained, so every known geometry and several unknown sizes are covered.
// ----------------------------------------------------------------------------

module disk_sector_chain_addresser_top_tb;

    import dsca_pkg::*;

    // Cycles without any handshake before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 100000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    link_in_t    in_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    link_out_t   out_word;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [19:0] cfg_image_size = '0;

    // Link words waiting to be driven, and results predicted for taken links.
    link_in_t    links_to_send[$];
    link_out_t   pending_results[$];
    int          links_queued = 0;
    int          links_taken = 0;

    // Predictor state: current image size and the marks of the open chain.
    logic [19:0] image_size_setting = '0;
    bit          chain_marks[int];

    bit          failed = 1'b0;
    int          quiet_cycles = 0;

    // Driver and monitor pacing.
    int          send_gap = 0;
    int          send_burst = 0;
    int          stall_left = 0;
    int          stall_burst = 0;

    disk_sector_chain_addresser_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_word        (in_word),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_word       (out_word),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_image_size (cfg_image_size)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Image length to disk format.
    function automatic fmt_t format_of(input logic [19:0] size);
        case (size)
            SIZE_35A, SIZE_35B, SIZE_40A, SIZE_40B, SIZE_42A, SIZE_42B:
                return FMT_SINGLE;
            SIZE_70A, SIZE_70B:
                return FMT_DOUBLE;
            SIZE_80A, SIZE_80B:
                return FMT_WIDE;
            default:
                return FMT_NONE;
        endcase
    endfunction

    // Highest valid track for an image length, 0 when the format is unknown.
    function automatic int last_track(input logic [19:0] size);
        int tracks;
        case (size)
            SIZE_35A, SIZE_35B: tracks = 35;
            SIZE_40A, SIZE_40B: tracks = 40;
            SIZE_42A, SIZE_42B: tracks = 42;
            SIZE_70A, SIZE_70B: tracks = 70;
            SIZE_80A, SIZE_80B: tracks = 80;
            default:            tracks = 0;
        endcase
        return (tracks < DEF_TRACK_CAP) ? tracks : DEF_TRACK_CAP;
    endfunction

    // Sectors on one track of a side, counted from track 1 of that side.
    function automatic int side_sectors(input int t);
        if (t <= 17)
            return 21;
        if (t <= 24)
            return 19;
        if (t <= 30)
            return 18;
        return 17;
    endfunction

    function automatic int sectors_per_track(input fmt_t f, input int t);
        if (f == FMT_WIDE)
            return int'(WIDE_COUNT);
        if (f == FMT_DOUBLE && t > 35)
            return side_sectors(t - 35);
        return side_sectors(t);
    endfunction

    // Sectors that precede a track, summed track by track.
    function automatic int sectors_ahead(input fmt_t f, input int t);
        int acc;
        acc = 0;
        for (int k = 1; k < t; k++)
            acc += sectors_per_track(f, k);
        return acc;
    endfunction

    // Expected result word for one taken link; updates the chain marks.
    function automatic link_out_t locate_link(input link_in_t w);
        link_out_t res;
        fmt_t      f;
        int        lim;
        int        mark;
        res = '0;
        f = format_of(image_size_setting);
        lim = last_track(image_size_setting);
        mark = int'(w.track) * 256 + int'(w.sector);
        if (w.cmd == CMD_START)
            chain_marks.delete();
        if (f == FMT_NONE) begin
            res.status = STAT_BAD;
        end else if (w.track == 8'd0) begin
            res.status = STAT_END;
        end else if (int'(w.track) > lim) begin
            res.status = STAT_LOOP;
        end else if (chain_marks.exists(mark)) begin
            res.status = STAT_LOOP;
        end else begin
            chain_marks[mark] = 1'b1;
            if (int'(w.sector) >= sectors_per_track(f, int'(w.track))) begin
                res.status = STAT_BAD;
            end else begin
                res.status = STAT_OK;
                res.byte_offset =
                    20'((sectors_ahead(f, int'(w.track)) + int'(w.sector)) * 256);
            end
        end
        return res;
    endfunction

    // Mostly short idle spans, now and then a long one.
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_link(input logic c, input logic [7:0] t, input logic [7:0] s);
        link_in_t w;
        w.cmd = c;
        w.track = t;
        w.sector = s;
        links_to_send = {links_to_send, w};
        links_queued++;
    endtask

    // Random chains under the current geometry: mostly fresh valid links,
    // with revisits, bad sectors, tracks past the image, ends and noise.
    task automatic queue_chains(input int n_links);
        fmt_t     f;
        int       lim;
        int       left;
        int       k;
        int       t;
        int       r;
        bit       first;
        link_in_t w;
        link_in_t trail[$];
        f = format_of(image_size_setting);
        lim = last_track(image_size_setting);
        left = n_links;
        while (left > 0) begin
            k = $urandom_range(1, 24);
            first = 1'b1;
            trail.delete();
            while (k > 0 && left > 0) begin
                r = $urandom_range(0, 99);
                w.cmd = first ? CMD_START : CMD_NEXT;
                if (lim == 0 || r >= 95) begin
                    w.cmd = 1'($urandom_range(0, 1));
                    w.track = 8'($urandom_range(0, 255));
                    w.sector = 8'($urandom_range(0, 255));
                end else if (r < 70) begin
                    t = $urandom_range(1, lim);
                    w.track = 8'(t);
                    w.sector = 8'($urandom_range(0, sectors_per_track(f, t) - 1));
                end else if (r < 80 && trail.size() > 0) begin
                    w = trail[$urandom_range(0, trail.size() - 1)];
                    w.cmd = CMD_NEXT;
                end else if (r < 85) begin
                    t = $urandom_range(1, lim);
                    w.track = 8'(t);
                    w.sector = 8'($urandom_range(sectors_per_track(f, t), 255));
                end else if (r < 90) begin
                    w.track = 8'($urandom_range(lim + 1, 255));
                    w.sector = 8'($urandom_range(0, 255));
                end else begin
                    w.track = 8'd0;
                    w.sector = 8'($urandom_range(0, 255));
                    k = 1;
                end
                queue_link(w.cmd, w.track, w.sector);
                trail = {trail, w};
                first = 1'b0;
                k--;
                left--;
            end
        end
    endtask

    // Wait until every queued link is taken and every result has come back.
    task automatic drain();
        while (links_taken != links_queued || pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_image_size(input logic [19:0] size);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_image_size <= size;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        image_size_setting = size;
    endtask

    // Driver: holds a stalled word, otherwise inserts a gap or sends the next.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_word <= '0;
        end else if (in_valid && in_stall) begin
            in_valid <= 1'b1;
        end else begin
            if (in_valid) begin
                pending_results = {pending_results, locate_link(in_word)};
                links_taken++;
            end
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (links_to_send.size() > 0) begin
                in_valid <= 1'b1;
                in_word <= links_to_send.pop_front();
                if (send_burst > 0) begin
                    send_burst--;
                end else if ($urandom_range(0, 39) == 0) begin
                    send_burst = $urandom_range(16, 64);
                end else begin
                    send_gap = idle_span();
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each taken result word and paces the output stall.
    always @(posedge clk or negedge rst_n)
    begin
        link_out_t want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result word with no link pending: offset %0d status %0d",
                             $time, out_word.byte_offset, out_word.status);
                    failed = 1'b1;
                end else begin
                    want = pending_results.pop_front();
                    if (out_word.byte_offset !== want.byte_offset) begin
                        $display("%0t: byte_offset expected %0d, got %0d",
                                 $time, want.byte_offset, out_word.byte_offset);
                        failed = 1'b1;
                    end
                    if (out_word.status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, out_word.status);
                        failed = 1'b1;
                    end
                end
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
                if (stall_burst > 0)
                    stall_burst--;
                else if ($urandom_range(0, 39) == 0)
                    stall_burst = $urandom_range(16, 64);
                else
                    stall_left = idle_span();
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [19:0] phase_sizes[12];
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Unknown format straight after reset.
        queue_link(CMD_START, 8'd1, 8'd0);
        queue_link(CMD_NEXT, 8'd0, 8'd0);
        drain();

        // Single sided: zone edges, loops, bad sector, end, tracks past the image.
        set_image_size(SIZE_35A);
        queue_link(CMD_START, 8'd18, 8'd0);
        queue_link(CMD_NEXT, 8'd18, 8'd0);
        queue_link(CMD_NEXT, 8'd17, 8'd20);
        queue_link(CMD_NEXT, 8'd17, 8'd21);
        queue_link(CMD_NEXT, 8'd17, 8'd21);
        queue_link(CMD_NEXT, 8'd0, 8'd255);
        queue_link(CMD_NEXT, 8'd35, 8'd16);
        queue_link(CMD_NEXT, 8'd36, 8'd0);
        queue_link(CMD_NEXT, 8'd255, 8'd255);
        queue_link(CMD_START, 8'd18, 8'd0);
        queue_link(CMD_NEXT, 8'd24, 8'd18);
        queue_link(CMD_NEXT, 8'd25, 8'd17);
        queue_link(CMD_NEXT, 8'd30, 8'd17);
        queue_link(CMD_NEXT, 8'd31, 8'd16);
        drain();

        // Double sided: second side zones and its last track.
        set_image_size(SIZE_70A);
        queue_link(CMD_START, 8'd36, 8'd20);
        queue_link(CMD_NEXT, 8'd70, 8'd16);
        queue_link(CMD_NEXT, 8'd70, 8'd17);
        queue_link(CMD_NEXT, 8'd71, 8'd0);
        drain();

        // Wide format: largest offset, first sector, one past each edge.
        set_image_size(SIZE_80B);
        queue_link(CMD_START, 8'd80, 8'd39);
        queue_link(CMD_NEXT, 8'd80, 8'd40);
        queue_link(CMD_NEXT, 8'd81, 8'd0);
        queue_link(CMD_NEXT, 8'd1, 8'd0);
        drain();

        // Random chains across every geometry and a few unknown sizes.
        phase_sizes = '{SIZE_35B, SIZE_40A, SIZE_40B, 20'd0, SIZE_42A, SIZE_42B,
                        SIZE_70B, 20'($urandom_range(0, 822400)), SIZE_80A,
                        SIZE_35A, 20'd822399, SIZE_80B};
        foreach (phase_sizes[i]) begin
            set_image_size(phase_sizes[i]);
            queue_chains((format_of(phase_sizes[i]) == FMT_NONE) ? 40 : 150);
            drain();
        end

        repeat (8) @(posedge clk);
        if (!failed && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
design/dsca_pkg.sv
design/dsca_ram.sv
design/dsca_geom.sv
design/dsca_ctrl.sv
design/disk_sector_chain_addresser_top.sv
sim/disk_sector_chain_addresser_top_tb.sv
